// ----- hdl/bfa_pkg.sv -----
// shared constants, codes and types of the bitmap first-free allocator
package bfa_pkg;

  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WORD_LOG   = $clog2(WORD_BITS);
  localparam int unsigned NUM_W      = 25;
  localparam int unsigned BIT_W      = NUM_W + 1;
  localparam int unsigned BLK_W      = 4;
  localparam int unsigned FDZ_W      = 24;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INODE_MAP_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MAP_BLOCKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_BASE        = 2'd2;

  // request codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_FREE    = 1'b1;
  localparam logic POOL_INODE = 1'b0;
  localparam logic POOL_ZONE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // first clear bit of one bitmap word
  typedef struct packed {
    logic                found;
    logic [WORD_LOG-1:0] idx;
  } find_res_t;

endpackage

// ----- hdl/bfa_ifs.sv -----
// request and response channel interfaces of the allocator
interface bfa_req_if;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic                    pool;
  logic [bfa_pkg::NUM_W-1:0] free_number;

  modport source (output valid, output opcode, output pool, output free_number, input ready);
  modport sink   (input valid, input opcode, input pool, input free_number, output ready);
endinterface

interface bfa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bfa_pkg::NUM_W-1:0]  granted_number;
  logic [bfa_pkg::STAT_W-1:0] status;

  modport source (output valid, output granted_number, output status, input ready);
  modport sink   (input valid, input granted_number, input status, output ready);
endinterface

// ----- hdl/bfa_find_free.sv -----
// lowest clear bit of one bitmap word within the valid span
module bfa_find_free (
  input  logic [bfa_pkg::WORD_BITS-1:0] word_i,
  input  logic [bfa_pkg::WORD_LOG:0]    span_i,
  output bfa_pkg::find_res_t            res_o
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] avail;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = !word_i[b] && ((WORD_LOG+1)'(b) < span_i);
    end
    res_o.found = |avail;
    res_o.idx   = '0;
    // walk down so the lowest clear bit wins
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res_o.idx = WORD_LOG'(b);
      end
    end
  end

endmodule

// ----- hdl/bitmap_first_free_allocator.sv -----
// top level of the bitmap first-free allocator
//
// Two allocation bitmaps (inode and zone) share one synchronous memory of 64-bit words,
// inode map in the lower half, zone map in the upper half. An allocate item streams
// one word per cycle out of the memory from word 0, finds the lowest clear bit inside
// the configured map size, sets it by a write-back and returns its number (plus
// the first data zone minus one for zones), or status full. A free item checks the
// number, reads the word, clears the bit and writes it back. One item is handled at a
// time; the memory read port sets the pace: an allocate scans words in order until it
// finds a clear bit, then passes through the grant and result states; a free passes
// through the check, read and modify states, or straight to the result when it is
// ignored as out of range; an allocate on an empty map goes straight to the result.
// After reset a clearing pass writes all 2 * MAP_WORDS memory words (2048 at the
// defaults) while no item is accepted; configuration writes are taken at any time
// but must only change while the block is idle. A finished result waits
// in the output register, so the next item is accepted while it is still pending.
module bitmap_first_free_allocator #(
  parameter int unsigned BLOCK_BYTES    = 1024,
  parameter int unsigned MAX_MAP_BLOCKS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bfa_req_if.sink                         req,
  bfa_rsp_if.source                       rsp,
  input  logic                            cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bfa_pkg::*;

  // map geometry
  localparam int unsigned BLK_BITS  = BLOCK_BYTES * 8;
  localparam int unsigned MAP_BITS  = MAX_MAP_BLOCKS * BLK_BITS;
  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned DEPTH     = 2 * MAP_WORDS;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned WIDX_W    = $clog2(MAP_WORDS);
  // holds any bit number of the map and the map size itself
  localparam int unsigned LIM_W     = WIDX_W + WORD_LOG + 1;

  // one-hot sequencer states
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FCHK  = 8'b0000_0100,
    S_FRD   = 8'b0000_1000,
    S_FMOD  = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_GRANT = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  // memory address of a word in the selected map
  function automatic logic [AW-1:0] map_addr(logic pool, logic [WIDX_W-1:0] widx);
    logic [AW-1:0] off;
    off = (pool == POOL_ZONE) ? AW'(MAP_WORDS) : '0;
    return off + AW'(widx);
  endfunction

  // configuration registers
  logic [BLK_W-1:0] inode_blocks_q, zone_blocks_q;
  logic [FDZ_W-1:0] fdz_q;

  // control state
  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            rvld_q, rvld_d;
  logic            out_vld_q;

  // item payload
  logic               pool_q;
  logic [NUM_W-1:0]   num_q;
  logic [LIM_W-1:0]   lim_q, lim_d;
  logic [WIDX_W-1:0]  w_q, w_d;
  logic [WIDX_W-1:0]  rw_q, rw_d;
  logic [WIDX_W-1:0]  fw_q, fw_d;
  logic [WORD_LOG-1:0] fb_q, fb_d;
  logic [LIM_W-1:0]   gbit_q, gbit_d;
  logic [NUM_W-1:0]   res_num_q, res_num_d;
  logic [STAT_W-1:0]  res_st_q, res_st_d;
  logic [NUM_W-1:0]   out_num_q;
  logic [STAT_W-1:0]  out_st_q;

  // memory
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // datapath helpers
  logic              acc;
  logic              out_ld;
  logic [BLK_W-1:0]  blk_sel, blk_sat;
  logic [LIM_W-1:0]  base, rem;
  logic [WORD_LOG:0] span;
  find_res_t         fr;
  logic [BIT_W-1:0]  fbit;
  logic              fbad;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign out_ld    = (state_q == S_RESP) && (!out_vld_q || rsp.ready);

  assign rsp.valid          = out_vld_q;
  assign rsp.granted_number = out_num_q;
  assign rsp.status         = out_st_q;

  // map size of the requested pool, block count saturated
  always_comb begin
    blk_sel = (req.pool == POOL_ZONE) ? zone_blocks_q : inode_blocks_q;
    if (32'(blk_sel) > MAX_MAP_BLOCKS) begin
      blk_sat = BLK_W'(MAX_MAP_BLOCKS);
    end else begin
      blk_sat = blk_sel;
    end
    lim_d = LIM_W'(blk_sat) * LIM_W'(BLK_BITS);
  end

  // span of map bits still inside the limit for the word in hand
  always_comb begin
    base = LIM_W'({rw_q, {WORD_LOG{1'b0}}});
    rem  = lim_q - base;
    if (rem >= LIM_W'(WORD_BITS)) begin
      span = (WORD_LOG+1)'(WORD_BITS);
    end else begin
      span = rem[WORD_LOG:0];
    end
  end

  bfa_find_free u_find (
    .word_i (rd_q),
    .span_i (span),
    .res_o  (fr)
  );

  // free number to map bit, and range check
  always_comb begin
    if (pool_q == POOL_ZONE) begin
      fbit = {1'b0, num_q} - BIT_W'(fdz_q) + BIT_W'(1);
    end else begin
      fbit = {1'b0, num_q};
    end
    fbad = ((pool_q == POOL_ZONE) && (num_q < NUM_W'(fdz_q))) ||
           (fbit == '0) || (fbit >= BIT_W'(lim_q));
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    rvld_d    = rvld_q;
    w_d       = w_q;
    rw_d      = rw_q;
    fw_d      = fw_q;
    fb_d      = fb_q;
    gbit_d    = gbit_q;
    res_num_d = res_num_q;
    res_st_d  = res_st_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_raddr = map_addr(pool_q, w_q);
    case (state_q)
      S_CLEAR: begin
        // reserved bit zero of each map is set
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0 || clr_q == AW'(MAP_WORDS)) ? WORD_BITS'(1) : '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (req.opcode == OP_FREE) begin
            state_d = S_FCHK;
          end else if (lim_d == '0) begin
            // empty map
            res_num_d = '0;
            res_st_d  = STAT_FULL;
            state_d   = S_RESP;
          end else begin
            w_d     = '0;
            rvld_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_FCHK: begin
        if (fbad) begin
          res_num_d = '0;
          res_st_d  = STAT_RANGE;
          state_d   = S_RESP;
        end else begin
          fw_d    = fbit[WORD_LOG +: WIDX_W];
          fb_d    = fbit[WORD_LOG-1:0];
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        mem_raddr = map_addr(pool_q, fw_q);
        state_d   = S_FMOD;
      end
      S_FMOD: begin
        mem_we    = 1'b1;
        mem_waddr = map_addr(pool_q, fw_q);
        mem_wdata = rd_q & ~(WORD_BITS'(1) << fb_q);
        res_num_d = '0;
        res_st_d  = STAT_DONE;
        state_d   = S_RESP;
      end
      S_SCAN: begin
        // stream reads, one word ahead of the check
        w_d    = w_q + WIDX_W'(1);
        rw_d   = w_q;
        rvld_d = 1'b1;
        if (rvld_q) begin
          if (fr.found) begin
            mem_we    = 1'b1;
            mem_waddr = map_addr(pool_q, rw_q);
            mem_wdata = rd_q | (WORD_BITS'(1) << fr.idx);
            gbit_d    = base + LIM_W'(fr.idx);
            state_d   = S_GRANT;
          end else if (rem <= LIM_W'(WORD_BITS)) begin
            // last word of the map had nothing free
            res_num_d = '0;
            res_st_d  = STAT_FULL;
            state_d   = S_RESP;
          end
        end
      end
      S_GRANT: begin
        if (pool_q == POOL_ZONE) begin
          res_num_d = NUM_W'(gbit_q) + NUM_W'(fdz_q) - NUM_W'(1);
        end else begin
          res_num_d = NUM_W'(gbit_q);
        end
        res_st_d = STAT_DONE;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (out_ld) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rvld_q  <= rvld_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_blocks_q <= BLK_W'(1);
      zone_blocks_q  <= BLK_W'(1);
      fdz_q          <= FDZ_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INODE_MAP_BLOCKS: inode_blocks_q <= cfg_data_i[BLK_W-1:0];
        CFG_ZONE_MAP_BLOCKS:  zone_blocks_q  <= cfg_data_i[BLK_W-1:0];
        CFG_ZONE_BASE:        fdz_q          <= cfg_data_i[FDZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      pool_q <= req.pool;
      num_q  <= req.free_number;
      lim_q  <= lim_d;
    end
    w_q       <= w_d;
    rw_q      <= rw_d;
    fw_q      <= fw_d;
    fb_q      <= fb_d;
    gbit_q    <= gbit_d;
    res_num_q <= res_num_d;
    res_st_q  <= res_st_d;
    if (out_ld) begin
      out_num_q <= res_num_q;
      out_st_q  <= res_st_q;
    end
  end

  // bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

endmodule

// ----- hdl/bfa_checker.sv -----
// port-level checks of the allocator, bound to the top level
module bfa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [bfa_pkg::NUM_W-1:0]  granted_i,
  input logic [bfa_pkg::STAT_W-1:0] status_i
);
  import bfa_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(granted_i) && $stable(status_i))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i == STAT_DONE || status_i == STAT_FULL ||
                     status_i == STAT_RANGE))
    else $error("undefined status code");

  // full maps and ignored frees carry no number
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != STAT_DONE |-> granted_i == '0)
    else $error("number granted with failing status");

  // clearing pass holds off items after reset
  a_reset_busy: assert property (@(posedge clk_i)
    !rst_ni |=> !req_ready_i)
    else $error("item accepted during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second item accepted back to back");

endmodule

bind bitmap_first_free_allocator bfa_checker u_bfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .granted_i   (rsp.granted_number),
  .status_i    (rsp.status)
);
